/* src/wrsn_pkg.sv */
// Shared constants and header tables for the WPA / RSN element parser.
`timescale 1ns / 1ps

package wrsn_pkg;

  // Element identifiers.
  localparam logic [7:0] ID_RSN = 8'h30;
  localparam logic [7:0] ID_WPA = 8'hdd;

  // Suite selector OUIs.
  localparam logic [23:0] OUI_WPA = 24'h0050f2;
  localparam logic [23:0] OUI_RSN = 24'h000fac;

  // Fixed header sizes in bytes, counted from the element id.
  localparam logic [3:0] HEAD_WPA = 4'd8;
  localparam logic [3:0] HEAD_RSN = 4'd4;

  // Bytes per suite selector and per PMKID, as shifts.
  localparam int SEL_BYTES_LOG2   = 2;
  localparam int PMKID_BYTES_LOG2 = 4;

  // Status codes, also used as the sticky error code.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER    = 3'd1;
  localparam logic [2:0] ST_PARTIAL_GROUP = 3'd2;
  localparam logic [2:0] ST_PAIR_COUNT    = 3'd3;
  localparam logic [2:0] ST_AKM_COUNT     = 3'd4;
  localparam logic [2:0] ST_ODD_PAIR      = 3'd5;
  localparam logic [2:0] ST_ODD_AKM       = 3'd6;
  localparam logic [2:0] ST_TRAILING      = 3'd7;

  // Cipher mask bits.
  localparam logic [4:0] CIPHER_NONE   = 5'b00001;
  localparam logic [4:0] CIPHER_WEP40  = 5'b00010;
  localparam logic [4:0] CIPHER_TKIP   = 5'b00100;
  localparam logic [4:0] CIPHER_CCMP   = 5'b01000;
  localparam logic [4:0] CIPHER_WEP104 = 5'b10000;

  // Suite type codes for ciphers.
  localparam logic [7:0] SUITE_NONE   = 8'd0;
  localparam logic [7:0] SUITE_WEP40  = 8'd1;
  localparam logic [7:0] SUITE_TKIP   = 8'd2;
  localparam logic [7:0] SUITE_CCMP   = 8'd4;
  localparam logic [7:0] SUITE_WEP104 = 8'd5;

  // Key management mask bits and suite type codes.
  localparam logic [1:0] AKM_8021X      = 2'b01;
  localparam logic [1:0] AKM_PSK        = 2'b10;
  localparam logic [7:0] SUITE_AKM_8021X = 8'd1;
  localparam logic [7:0] SUITE_AKM_PSK   = 8'd2;

  // Expected header byte at a given position; the length byte is never compared.
  function automatic logic [7:0] head_byte(input logic rsn, input logic [2:0] idx);
    logic [7:0] val;
    val = 8'h00;
    if (rsn) begin
      case (idx)
        3'd0:    val = ID_RSN;
        3'd2:    val = 8'h01;
        default: val = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    val = ID_WPA;
        3'd3:    val = 8'h50;
        3'd4:    val = 8'hf2;
        3'd5:    val = 8'h01;
        3'd6:    val = 8'h01;
        default: val = 8'h00;
      endcase
    end
    return val;
  endfunction

endpackage

/* src/wpa_rsn_ie_parser_core.sv */
// WPA / RSN information element parser, top level.
//
// Bytes of one element enter on the input channel (ie_byte, last_byte,
// in_valid, in_stall), starting with the element id, one item per cycle while in_stall is low.
// The item that carries last_byte closes the element and produces one
// result item on the output channel (status, is_rsn, the cipher and key
// management masks, preauth, pmkid_count, pmkid_offset, out_valid,
// out_stall). Other items produce no result.
// Each accepted item is first held in an input register and is then
// folded into the parser state; the result of a closing item is loaded
// from the input register into the output register. The block takes
// one item every cycle while in_stall is low. The input register only
// waits when it holds a closing item while the output register still
// holds an untaken result, so in_stall follows out_stall for that case alone.
// Reset (rst, synchronous) empties both registers and returns the parser
// to expect an element id. After each closing item the parser restarts
// on its own for the next element.
`timescale 1ns / 1ps

module wpa_rsn_ie_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ie_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        is_rsn,
  output logic [4:0]  grp_ciphers,
  output logic [4:0]  pairwise_ciphers,
  output logic [1:0]  akm_types,
  output logic        preauth,
  output logic [15:0] pmkid_count,
  output logic [8:0]  pmkid_offset
);

  typedef enum logic [3:0] {
    PH_ID,
    PH_LEN,
    PH_HDR,
    PH_GROUP,
    PH_PCNT,
    PH_PLIST,
    PH_ACNT,
    PH_ALIST,
    PH_CAP,
    PH_KCNT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] err;
  } field_open_t;

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       hold_adv;

  // Parser state.
  phase_t      parse_phase;
  logic [8:0]  byte_position;
  logic [7:0]  declared_length;
  logic [31:0] selector_shift;
  logic [2:0]  field_index;
  logic [15:0] list_count;
  logic        rsn_flag;
  logic [4:0]  group_mask;
  logic [4:0]  pairwise_mask;
  logic [1:0]  akm_mask;
  logic        preauth_flag;
  logic [15:0] pmkid_number;
  logic [8:0]  pmkid_start;
  logic [2:0]  error_code;

  phase_t      parse_phase_next;
  logic [8:0]  byte_position_next;
  logic [7:0]  declared_length_next;
  logic [31:0] selector_shift_next;
  logic [2:0]  field_index_next;
  logic [15:0] list_count_next;
  logic        rsn_flag_next;
  logic [4:0]  group_mask_next;
  logic [4:0]  pairwise_mask_next;
  logic [1:0]  akm_mask_next;
  logic        preauth_flag_next;
  logic [15:0] pmkid_number_next;
  logic [8:0]  pmkid_start_next;
  logic [2:0]  error_code_next;

  // Result values of a closing item.
  logic [2:0]  res_status;
  logic        res_ok;
  logic [8:0]  res_end;

  // Helpers derived from the current state and the held byte.
  logic [9:0]  pos_inc;
  logic [8:0]  elem_end;
  logic [3:0]  head;
  logic [8:0]  rem_head;
  logic [8:0]  rem_inc;
  logic [31:0] shift_take;
  logic [2:0]  index_take;
  logic [15:0] count_le;
  logic [15:0] list_dec;
  logic        list_short;
  logic        pmkid_short;
  field_open_t open_res;

  // Bytes left from position p to the end the length byte declares.
  function automatic logic [8:0] remaining(input logic [8:0] e, input logic [9:0] p);
    logic [9:0] e_wide;
    e_wide = {1'b0, e};
    return (e_wide > p) ? 9'(e_wide - p) : 9'd0;
  endfunction

  // Cipher suite selector to mask; a foreign OUI or unknown type gives zero.
  function automatic logic [4:0] cipher_bits(input logic [31:0] sel, input logic rsn);
    logic [4:0] bits;
    bits = 5'd0;
    if (sel[31:8] == (rsn ? wrsn_pkg::OUI_RSN : wrsn_pkg::OUI_WPA)) begin
      case (sel[7:0])
        wrsn_pkg::SUITE_NONE:   bits = wrsn_pkg::CIPHER_NONE;
        wrsn_pkg::SUITE_WEP40:  bits = wrsn_pkg::CIPHER_WEP40;
        wrsn_pkg::SUITE_TKIP:   bits = wrsn_pkg::CIPHER_TKIP;
        wrsn_pkg::SUITE_CCMP:   bits = wrsn_pkg::CIPHER_CCMP;
        wrsn_pkg::SUITE_WEP104: bits = wrsn_pkg::CIPHER_WEP104;
        default:                bits = 5'd0;
      endcase
    end
    return bits;
  endfunction

  // Key management suite selector to mask.
  function automatic logic [1:0] akm_bits(input logic [31:0] sel, input logic rsn);
    logic [1:0] bits;
    bits = 2'd0;
    if (sel[31:8] == (rsn ? wrsn_pkg::OUI_RSN : wrsn_pkg::OUI_WPA)) begin
      case (sel[7:0])
        wrsn_pkg::SUITE_AKM_8021X: bits = wrsn_pkg::AKM_8021X;
        wrsn_pkg::SUITE_AKM_PSK:   bits = wrsn_pkg::AKM_PSK;
        default:                   bits = 2'd0;
      endcase
    end
    return bits;
  endfunction

  // Decide how the next optional field starts from the bytes that are left.
  function automatic field_open_t open_field(input phase_t kind, input logic [8:0] rem,
                                             input logic rsn, input phase_t cur);
    field_open_t r;
    r.phase = cur;
    r.err   = wrsn_pkg::ST_OK;
    if (rem == 9'd0) begin
      r.phase = PH_DONE;
    end else begin
      case (kind)
        PH_GROUP: begin
          if (rem < 9'd4) r.err = wrsn_pkg::ST_PARTIAL_GROUP;
          else r.phase = PH_GROUP;
        end
        PH_PCNT: begin
          if (rem < 9'd2) r.err = wrsn_pkg::ST_ODD_PAIR;
          else r.phase = PH_PCNT;
        end
        PH_ACNT: begin
          if (rem < 9'd2) r.err = wrsn_pkg::ST_ODD_AKM;
          else r.phase = PH_ACNT;
        end
        PH_CAP: begin
          if (rem >= 9'd2) r.phase = PH_CAP;
          else if (rsn) r.phase = PH_DONE;
          else r.err = wrsn_pkg::ST_TRAILING;
        end
        default: begin
          if (rem >= 9'd2) r.phase = PH_KCNT;
          else r.phase = PH_DONE;
        end
      endcase
    end
    return r;
  endfunction

  // Handshake: only a closing item can wait, and only for the output register.
  assign hold_adv = !hold_last || !out_valid || !out_stall;
  assign in_stall = hold_valid && !hold_adv;

  // Positions, remaining byte counts and the selector shift of this byte.
  assign pos_inc     = {1'b0, byte_position} + 10'd1;
  assign elem_end    = {1'b0, declared_length} + 9'd2;
  assign head        = rsn_flag ? wrsn_pkg::HEAD_RSN : wrsn_pkg::HEAD_WPA;
  assign rem_head    = remaining(elem_end, {6'd0, head});
  assign rem_inc     = remaining(elem_end, pos_inc);
  assign shift_take  = {selector_shift[23:0], hold_byte};
  assign index_take  = field_index + 3'd1;
  assign count_le    = {shift_take[7:0], shift_take[15:8]};
  assign list_dec    = list_count - 16'd1;
  assign list_short  = {9'd0, rem_inc} < (18'(count_le) << wrsn_pkg::SEL_BYTES_LOG2);
  assign pmkid_short = {11'd0, rem_inc} < (20'(count_le) << wrsn_pkg::PMKID_BYTES_LOG2);

  // Fold one byte into the parser state.
  always_comb begin
    parse_phase_next     = parse_phase;
    byte_position_next   = (byte_position != 9'h1ff) ? pos_inc[8:0] : byte_position;
    declared_length_next = declared_length;
    selector_shift_next  = selector_shift;
    field_index_next     = field_index;
    list_count_next      = list_count;
    rsn_flag_next        = rsn_flag;
    group_mask_next      = group_mask;
    pairwise_mask_next   = pairwise_mask;
    akm_mask_next        = akm_mask;
    preauth_flag_next    = preauth_flag;
    pmkid_number_next    = pmkid_number;
    pmkid_start_next     = pmkid_start;
    error_code_next      = error_code;
    open_res             = '{phase: parse_phase, err: wrsn_pkg::ST_OK};

    if (error_code == wrsn_pkg::ST_OK) begin
      case (parse_phase)
        PH_ID: begin
          rsn_flag_next      = (hold_byte == wrsn_pkg::ID_RSN);
          group_mask_next    = (hold_byte == wrsn_pkg::ID_RSN) ? wrsn_pkg::CIPHER_CCMP
                                                                : wrsn_pkg::CIPHER_TKIP;
          pairwise_mask_next = group_mask_next;
          akm_mask_next      = wrsn_pkg::AKM_8021X;
          if (hold_byte != wrsn_pkg::ID_RSN && hold_byte != wrsn_pkg::ID_WPA) begin
            error_code_next = wrsn_pkg::ST_BAD_HEADER;
          end
          parse_phase_next = PH_LEN;
        end
        PH_LEN: begin
          declared_length_next = hold_byte;
          if (({1'b0, hold_byte} + 9'd2) < {5'd0, head}) begin
            error_code_next = wrsn_pkg::ST_BAD_HEADER;
          end
          parse_phase_next = PH_HDR;
        end
        PH_HDR: begin
          if (hold_byte != wrsn_pkg::head_byte(rsn_flag, byte_position[2:0])) begin
            error_code_next = wrsn_pkg::ST_BAD_HEADER;
          end else if (pos_inc >= {6'd0, head}) begin
            open_res            = open_field(PH_GROUP, rem_head, rsn_flag, parse_phase);
            parse_phase_next    = open_res.phase;
            error_code_next     = open_res.err;
            field_index_next    = 3'd0;
            selector_shift_next = 32'd0;
          end
        end
        PH_GROUP: begin
          selector_shift_next = shift_take;
          field_index_next    = index_take;
          if (index_take >= 3'd4) begin
            group_mask_next     = cipher_bits(shift_take, rsn_flag);
            open_res            = open_field(PH_PCNT, rem_inc, rsn_flag, parse_phase);
            parse_phase_next    = open_res.phase;
            error_code_next     = open_res.err;
            field_index_next    = 3'd0;
            selector_shift_next = 32'd0;
          end
        end
        PH_PCNT, PH_ACNT: begin
          selector_shift_next = shift_take;
          field_index_next    = index_take;
          if (index_take >= 3'd2) begin
            if (count_le == 16'd0 || list_short) begin
              error_code_next = (parse_phase == PH_PCNT) ? wrsn_pkg::ST_PAIR_COUNT
                                                         : wrsn_pkg::ST_AKM_COUNT;
            end else begin
              list_count_next = count_le;
              if (parse_phase == PH_PCNT) begin
                pairwise_mask_next = 5'd0;
                parse_phase_next   = PH_PLIST;
              end else begin
                akm_mask_next    = 2'd0;
                parse_phase_next = PH_ALIST;
              end
              field_index_next    = 3'd0;
              selector_shift_next = 32'd0;
            end
          end
        end
        PH_PLIST, PH_ALIST: begin
          selector_shift_next = shift_take;
          field_index_next    = index_take;
          if (index_take >= 3'd4) begin
            if (parse_phase == PH_PLIST) begin
              pairwise_mask_next = pairwise_mask | cipher_bits(shift_take, rsn_flag);
            end else begin
              akm_mask_next = akm_mask | akm_bits(shift_take, rsn_flag);
            end
            list_count_next     = list_dec;
            field_index_next    = 3'd0;
            selector_shift_next = 32'd0;
            if (list_dec == 16'd0) begin
              open_res = open_field((parse_phase == PH_PLIST) ? PH_ACNT : PH_CAP,
                                    rem_inc, rsn_flag, parse_phase);
              parse_phase_next = open_res.phase;
              error_code_next  = open_res.err;
            end
          end
        end
        PH_CAP: begin
          if (field_index == 3'd0) begin
            preauth_flag_next = hold_byte[0];
          end
          selector_shift_next = shift_take;
          field_index_next    = index_take;
          if (index_take >= 3'd2) begin
            if (rsn_flag) begin
              open_res            = open_field(PH_KCNT, rem_inc, rsn_flag, parse_phase);
              parse_phase_next    = open_res.phase;
              error_code_next     = open_res.err;
              field_index_next    = 3'd0;
              selector_shift_next = 32'd0;
            end else if (rem_inc != 9'd0) begin
              error_code_next = wrsn_pkg::ST_TRAILING;
            end else begin
              parse_phase_next = PH_DONE;
            end
          end
        end
        PH_KCNT: begin
          selector_shift_next = shift_take;
          field_index_next    = index_take;
          if (index_take >= 3'd2) begin
            if (pmkid_short) begin
              pmkid_number_next = 16'd0;
            end else begin
              pmkid_number_next = count_le;
              pmkid_start_next  = (count_le != 16'd0) ? pos_inc[8:0] : 9'd0;
            end
            parse_phase_next = PH_DONE;
          end
        end
        default: begin
          parse_phase_next = parse_phase;
        end
      endcase
    end
  end

  // Result of a closing item; the size check always wins.
  assign res_end    = {1'b0, declared_length_next} + 9'd2;
  assign res_status = (pos_inc != {1'b0, res_end}) ? wrsn_pkg::ST_BAD_HEADER : error_code_next;
  assign res_ok     = (res_status == wrsn_pkg::ST_OK);

  // Input register, parser state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid      <= 1'b0;
      out_valid       <= 1'b0;
      parse_phase     <= PH_ID;
      byte_position   <= 9'd0;
      declared_length <= 8'd0;
      selector_shift  <= 32'd0;
      field_index     <= 3'd0;
      list_count      <= 16'd0;
      rsn_flag        <= 1'b0;
      group_mask      <= 5'd0;
      pairwise_mask   <= 5'd0;
      akm_mask        <= 2'd0;
      preauth_flag    <= 1'b0;
      pmkid_number    <= 16'd0;
      pmkid_start     <= 9'd0;
      error_code      <= wrsn_pkg::ST_OK;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
        hold_byte  <= ie_byte;
        hold_last  <= last_byte;
      end

      if (hold_valid && hold_adv && hold_last) begin
        out_valid        <= 1'b1;
        status           <= res_status;
        is_rsn           <= rsn_flag_next;
        grp_ciphers      <= res_ok ? group_mask_next : 5'd0;
        pairwise_ciphers <= res_ok ? pairwise_mask_next : 5'd0;
        akm_types        <= res_ok ? akm_mask_next : 2'd0;
        preauth          <= res_ok && preauth_flag_next;
        pmkid_count      <= res_ok ? pmkid_number_next : 16'd0;
        pmkid_offset     <= (res_ok && pmkid_number_next != 16'd0) ? pmkid_start_next : 9'd0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (hold_valid && hold_adv) begin
        if (hold_last) begin
          // The element is closed: start over for the next one.
          parse_phase     <= PH_ID;
          byte_position   <= 9'd0;
          declared_length <= 8'd0;
          selector_shift  <= 32'd0;
          field_index     <= 3'd0;
          list_count      <= 16'd0;
          rsn_flag        <= 1'b0;
          group_mask      <= 5'd0;
          pairwise_mask   <= 5'd0;
          akm_mask        <= 2'd0;
          preauth_flag    <= 1'b0;
          pmkid_number    <= 16'd0;
          pmkid_start     <= 9'd0;
          error_code      <= wrsn_pkg::ST_OK;
        end else begin
          parse_phase     <= parse_phase_next;
          byte_position   <= byte_position_next;
          declared_length <= declared_length_next;
          selector_shift  <= selector_shift_next;
          field_index     <= field_index_next;
          list_count      <= list_count_next;
          rsn_flag        <= rsn_flag_next;
          group_mask      <= group_mask_next;
          pairwise_mask   <= pairwise_mask_next;
          akm_mask        <= akm_mask_next;
          preauth_flag    <= preauth_flag_next;
          pmkid_number    <= pmkid_number_next;
          pmkid_start     <= pmkid_start_next;
          error_code      <= error_code_next;
        end
      end
    end
  end

  // A failed element reports no decoded fields.
  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != wrsn_pkg::ST_OK) |->
      (grp_ciphers == 5'd0 && pairwise_ciphers == 5'd0 && akm_types == 2'd0 &&
       !preauth && pmkid_count == 16'd0 && pmkid_offset == 9'd0))
    else $error("error result carries decoded fields");

  // A PMKID offset is only given together with a PMKID count.
  a_offset_needs_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pmkid_count == 16'd0) |-> (pmkid_offset == 9'd0))
    else $error("PMKID offset without PMKID count");

  // A closing item returns the parser to its start state.
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold_adv && hold_last) |=>
      (byte_position == 9'd0 && parse_phase == PH_ID && error_code == wrsn_pkg::ST_OK))
    else $error("parser did not restart after a closing item");

  // The input side only waits behind an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && hold_last && out_valid && out_stall))
    else $error("input stalled without a pending result");

  // Once an error is latched it holds until the element closes.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold_adv && !hold_last && error_code != wrsn_pkg::ST_OK) |=>
      (error_code == $past(error_code)))
    else $error("latched error code changed inside an element");

endmodule
